[src/alid_pkg.sv]
package alid_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_FIND   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADPOS   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic                    cmp_en;
		logic [CNT_W-1:0]        pos;
		logic [CNT_W-1:0]        count;
		logic signed [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

[src/array_list_insert_delete_find_core.sv]
// An accepted item is registered; the cell row then updates or compares in the
// execute step, and the encode step priority encodes the match vector once the
// output register is free. The core takes no new item until the last is encoded.
// A finished result may wait in the output register while the next item is taken.
// Reset clears the count to an empty list and drops any pending result;
// the entries themselves are not cleared.
module array_list_insert_delete_find_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [5:0]  position,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [4:0]  found_index,
	output logic [5:0]  entry_count
);
	import alid_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_ENC  = 2'd2;

	logic [1:0]              state_q;
	logic [1:0]              kind_q;
	logic [CNT_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CNT_W-1:0]        count_q;
	logic [1:0]              pre_status_q;
	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic [IDX_W-1:0]        found_q;
	logic [CNT_W-1:0]        res_count_q;

	cell_cmd_t               cmd;
	logic [1:0]              exec_status;
	logic signed [VAL_W-1:0] entries [DEPTH];
	logic [DEPTH-1:0]        hit_vec;
	logic [IDX_W-1:0]        hit_idx;
	logic                    enc_go;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = 5'(found_q);
	assign entry_count = 6'(res_count_q);
	assign enc_go      = (state_q == S_ENC) && (!out_valid_q || out_ready);

	always_comb begin
		exec_status = ST_OK;
		case (kind_q)
			KIND_INSERT: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					exec_status = ST_FULL;
				end else if (pos_q > count_q) begin
					exec_status = ST_BADPOS;
				end
			end
			KIND_DELETE: begin
				if (pos_q >= count_q) begin
					exec_status = ST_BADPOS;
				end
			end
			default: exec_status = ST_OK;
		endcase
	end

	always_comb begin
		cmd.ins_en = (state_q == S_EXEC) && (kind_q == KIND_INSERT) && (exec_status == ST_OK);
		cmd.del_en = (state_q == S_EXEC) && (kind_q == KIND_DELETE) && (exec_status == ST_OK);
		cmd.cmp_en = (state_q == S_EXEC) && (kind_q == KIND_FIND);
		cmd.pos    = pos_q;
		cmd.count  = count_q;
		cmd.value  = value_q;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		alid_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.cell_idx   (IDX_W'(g)),
			.left_entry (entries[(g == 0) ? 0 : g - 1]),
			.right_entry(entries[(g == DEPTH - 1) ? g : g + 1]),
			.entry      (entries[g]),
			.match      (hit_vec[g])
		);
	end

	always_comb begin
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind;
			pos_q   <= CNT_W'(position);
			value_q <= value;
		end
		if (state_q == S_EXEC) begin
			pre_status_q <= exec_status;
		end
		if (enc_go) begin
			res_count_q <= count_q;
			if (kind_q == KIND_FIND) begin
				status_q <= (|hit_vec) ? ST_OK : ST_NOTFOUND;
				found_q  <= (|hit_vec) ? hit_idx : '0;
			end else begin
				status_q <= pre_status_q;
				found_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.ins_en) begin
						count_q <= count_q + 1'b1;
					end else if (cmd.del_en) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_ENC;
				end
				S_ENC: begin
					if (enc_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (enc_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Entry count exceeds the list depth.");

	a_count_only_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_EXEC))
		else $error("Entry count changed outside the execute step.");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FULL) |-> (res_count_q == CNT_W'(DEPTH)))
		else $error("List full reported while the list has room.");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && (status_q != ST_OK) |-> (found_q == '0))
		else $error("Found index set on a result that is not a successful find.");
`endif

endmodule

[src/alid_cell.sv]
module alid_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  alid_pkg::cell_cmd_t            cmd,
	input  logic [alid_pkg::IDX_W-1:0]     cell_idx,
	input  logic signed [alid_pkg::VAL_W-1:0] left_entry,
	input  logic signed [alid_pkg::VAL_W-1:0] right_entry,
	output logic signed [alid_pkg::VAL_W-1:0] entry,
	output logic                           match
);
	import alid_pkg::*;

	logic signed [VAL_W-1:0] entry_q;
	logic                    match_q;
	logic [CNT_W-1:0]        idx_ext;

	assign idx_ext = CNT_W'(cell_idx);
	assign entry   = entry_q;
	assign match   = match_q;

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (idx_ext == cmd.pos) begin
				entry_q <= cmd.value;
			end else if (idx_ext > cmd.pos) begin
				entry_q <= left_entry;
			end
		end else if (cmd.del_en) begin
			if (idx_ext >= cmd.pos) begin
				entry_q <= right_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmd.cmp_en) begin
			match_q <= (entry_q == cmd.value) && (idx_ext < cmd.count);
		end
	end

endmodule

[verif/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import alid_pkg::*;

	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [1:0]              kind;
		logic [5:0]              position;
		logic signed [VAL_W-1:0] value;
	} list_op_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] found_index;
		logic [5:0] entry_count;
	} list_res_t;

	typedef struct packed {
		logic [DEPTH-1:0][VAL_W-1:0] cells;
		logic [CNT_W-1:0]            cnt;
	} list_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [5:0] position = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [4:0] found_index;
	logic [5:0] entry_count;

	list_op_t pend_q[$];
	list_op_t nxt_op;
	list_res_t exp_q[$];
	list_res_t want;
	list_state_t list_model;
	list_state_t gen_list = '0;
	bit filling = 1'b1;
	bit timed_out = 1'b0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cnt = 0;
	int err_cnt = 0;
	int n_in = 0;
	int n_out = 0;
	int peak_cnt = 0;
	int fill_rounds = 0;
	int tally [4] = '{0, 0, 0, 0};

	array_list_insert_delete_find_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_index (found_index),
		.entry_count (entry_count)
	);

	initial forever #6 clk = ~clk;

	function automatic list_res_t apply_op(inout list_state_t st, input list_op_t op);
		list_res_t r;
		bit hit;
		r = '0;
		hit = 1'b0;
		case (op.kind)
			KIND_INSERT: begin
				if (st.cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else if (op.position > st.cnt) begin
					r.status = ST_BADPOS;
				end else begin
					for (int i = int'(st.cnt); i > int'(op.position); i--)
						st.cells[i] = st.cells[i-1];
					st.cells[op.position] = op.value;
					st.cnt = st.cnt + 1'b1;
				end
			end
			KIND_DELETE: begin
				if (op.position >= st.cnt) begin
					r.status = ST_BADPOS;
				end else begin
					for (int i = int'(op.position); i + 1 < int'(st.cnt); i++)
						st.cells[i] = st.cells[i+1];
					st.cnt = st.cnt - 1'b1;
				end
			end
			KIND_FIND: begin
				r.status = ST_NOTFOUND;
				for (int i = 0; i < int'(st.cnt); i++) begin
					if (!hit && st.cells[i] == op.value) begin
						hit = 1'b1;
						r.status = ST_OK;
						r.found_index = i[4:0];
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = st.cnt;
		return r;
	endfunction

	function automatic list_op_t make_op();
		list_op_t op;
		int c;
		int r;
		c = int'(gen_list.cnt);
		r = $urandom_range(99);
		if (filling)
			op.kind = (r < 60) ? KIND_INSERT : (r < 75) ? KIND_DELETE :
				(r < 95) ? KIND_FIND : KIND_NOP;
		else
			op.kind = (r < 15) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
				(r < 95) ? KIND_FIND : KIND_NOP;
		r = $urandom_range(99);
		if (r < 80)
			op.position = (op.kind == KIND_DELETE) ?
				((c > 0) ? 6'($urandom_range(c - 1)) : 6'd0) : 6'($urandom_range(c));
		else if (r < 90)
			op.position = 6'(c);
		else
			op.position = 6'($urandom_range(63));
		r = $urandom_range(99);
		if (r < 40 && c > 0) begin
			op.value = gen_list.cells[$urandom_range(c - 1)];
		end else if (r < 70) begin
			case ($urandom_range(6))
				0: op.value = 32'sh8000_0000;
				1: op.value = 32'sh7FFF_FFFF;
				2: op.value = -1;
				3: op.value = 0;
				4: op.value = 1;
				5: op.value = 32'sh5555_5555;
				default: op.value = -2;
			endcase
		end else begin
			op.value = $urandom;
		end
		return op;
	endfunction

	task automatic queue_op(input list_op_t op);
		pend_q.push_back(op);
		void'(apply_op(gen_list, op));
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			queue_op(make_op());
			if (filling && gen_list.cnt == DEPTH && $urandom_range(7) == 0) begin
				filling = 1'b0;
				fill_rounds++;
			end else if (!filling && gen_list.cnt == 0) begin
				filling = 1'b1;
			end
		end
	endtask

	task automatic report_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			position <= '0;
			value <= '0;
		end else if (!in_valid || in_ready) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt_op = pend_q.pop_front();
				in_valid <= 1'b1;
				kind <= nxt_op.kind;
				position <= nxt_op.position;
				value <= nxt_op.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_model = '0;
			exp_q.delete();
			quiet_cnt = 0;
		end else begin
			if (in_valid && in_ready) begin
				exp_q.push_back(apply_op(list_model, list_op_t'({kind, position, value})));
				n_in++;
				if (list_model.cnt > peak_cnt)
					peak_cnt = int'(list_model.cnt);
			end
			if (out_valid && out_ready) begin
				n_out++;
				if (!$isunknown(status))
					tally[status]++;
				if (exp_q.size() == 0) begin
					report_error($sformatf("unexpected result status %0d index %0d count %0d",
						status, found_index, entry_count));
				end else begin
					want = exp_q.pop_front();
					if (want.status !== status || want.found_index !== found_index ||
						want.entry_count !== entry_count)
						report_error($sformatf({"result %0d: expected status %0d index %0d ",
							"count %0d, got status %0d index %0d count %0d"}, n_out,
							want.status, want.found_index, want.entry_count,
							status, found_index, entry_count));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(!in_valid && exp_q.size() == 0))
				quiet_cnt = 0;
			else
				quiet_cnt++;
			if (quiet_cnt >= STALL_LIMIT)
				timed_out = 1'b1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 4 && !timed_out; ph++) begin
			@(negedge clk);
			idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 48 : 15) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 48 : 15) : 0;
			if (ph == 0) begin
				queue_op('{KIND_FIND, 6'd0, 32'sd0});
				queue_op('{KIND_DELETE, 6'd0, 32'sd5});
				queue_op('{KIND_INSERT, 6'd1, 32'sd7});
				queue_op('{KIND_INSERT, 6'd63, -32'sd1});
				queue_op('{KIND_INSERT, 6'd0, 32'sh8000_0000});
				queue_op('{KIND_INSERT, 6'd1, 32'sh7FFF_FFFF});
				queue_op('{KIND_INSERT, 6'd0, -32'sd1});
				queue_op('{KIND_INSERT, 6'd1, 32'sd0});
				queue_op('{KIND_INSERT, 6'd5, 32'sd9});
				queue_op('{KIND_FIND, 6'd63, 32'sh7FFF_FFFF});
				queue_op('{KIND_FIND, 6'd0, 32'sh8000_0000});
				queue_op('{KIND_FIND, 6'd21, 32'sd12345});
				queue_op('{KIND_NOP, 6'd63, -32'sd1});
				queue_op('{KIND_INSERT, 6'd4, -32'sd1});
				queue_op('{KIND_FIND, 6'd0, -32'sd1});
				queue_op('{KIND_DELETE, 6'd4, 32'sd0});
				queue_op('{KIND_DELETE, 6'd4, 32'sd0});
				queue_op('{KIND_DELETE, 6'd0, 32'sd0});
				queue_op('{KIND_FIND, 6'd0, -32'sd1});
				queue_op('{KIND_DELETE, 6'd63, 32'sd0});
				queue_random(270);
				wait (n_in >= 60 || timed_out);
				@(negedge clk);
				hold_req++;
			end else begin
				queue_random(290);
			end
			while (!timed_out && (pend_q.size() != 0 || in_valid || exp_q.size() != 0))
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Ran %0d list operations, %0d results checked, %0d mismatches.",
			n_in, n_out, err_cnt);
		$display("Status seen: %0d ok, %0d full, %0d bad position, %0d not found; %0d %s %0d.",
			tally[ST_OK], tally[ST_FULL], tally[ST_BADPOS], tally[ST_NOTFOUND],
			fill_rounds, "fill and drain rounds, peak count", peak_cnt);
		if (!timed_out && err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[array_list_insert_delete_find_core.f]
src/alid_pkg.sv
src/alid_cell.sv
src/array_list_insert_delete_find_core.sv
verif/tb_top.sv
